>>> design/hsfc_pkg.sv
`timescale 1ns / 1ps

package hsfc_pkg;

  localparam logic [15:0] HalfQnan = 16'h7e00;
  localparam logic [15:0] HalfInf  = 16'h7c00;

  typedef enum logic {
    OP_S2H = 1'b0,
    OP_H2S = 1'b1
  } op_e;

  // Single to half: rebias, truncate, shift into subnormal range, flush tiny values.
  function automatic logic [15:0] single_to_half(input logic [31:0] x);
    logic [15:0] sgn;
    logic signed [9:0] ex;
    logic [22:0] man;
    logic [23:0] full;
    logic [4:0] sh;
    logic [23:0] shifted;
    logic [15:0] res;
    sgn = {x[31], 15'd0};
    ex = $signed({2'b00, x[30:23]}) - 10'sd112;
    man = x[22:0];
    full = {1'b1, man};
    sh = 5'(10'sd14 - ex);
    shifted = full >> sh;
    if (ex <= 10'sd0) begin
      if (ex < -10'sd10) res = sgn;
      else res = sgn | shifted[15:0];
    end else if (ex == 10'sd143) begin
      res = (man != 23'd0) ? (sgn | HalfQnan) : (sgn | HalfInf);
    end else if (ex > 10'sd30) begin
      res = sgn | HalfInf;
    end else begin
      res = {x[31], ex[4:0], man[22:13]};
    end
    return res;
  endfunction

  // Half to single: exact; subnormals normalized by a leading-zero count.
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0] ex;
    logic [9:0] man;
    logic [3:0] lz;
    logic found;
    logic [9:0] m;
    logic [31:0] res;
    ex = h[14:10];
    man = h[9:0];
    lz = 4'd0;
    found = 1'b0;
    for (int i = 9; i >= 0; i--) begin
      if (!found && man[i]) begin
        found = 1'b1;
        lz = 4'(9 - i);
      end
    end
    m = 10'(man << (lz + 4'd1));
    if (ex == 5'd0) begin
      if (man == 10'd0) res = {h[15], 31'd0};
      else res = {h[15], 8'(8'd112 - {4'd0, lz}), m, 13'd0};
    end else if (ex == 5'h1f) begin
      res = {h[15], 8'hff, man, 13'd0};
    end else begin
      res = {h[15], 8'({3'd0, ex} + 8'd112), man, 13'd0};
    end
    return res;
  endfunction

endpackage

>>> design/half_single_float_converter.sv
`timescale 1ns / 1ps

// Half/single float converter. One transaction per cycle: an input register
// feeds one level of conversion logic into the result register, and a new
// transaction is taken every cycle unless both registers are full and the
// result is stalled. No rounding on single to half (truncation).
module half_single_float_converter
  import hsfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic        op_i,
  input  logic [31:0] single_bits_i,
  input  logic [15:0] half_bits_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] converted_bits_o
);

  logic        in_vld_q;
  logic        op_q;
  logic [31:0] sb_q;
  logic [15:0] hb_q;
  logic        out_vld_q;
  logic [31:0] res_q;
  logic [31:0] res_d;
  logic        out_adv;
  logic        in_adv;

  // Advance result stage when empty or taken; input stage when it can drain.
  assign out_adv = !out_vld_q || !stall_i;
  assign in_adv  = !in_vld_q || out_adv;
  assign stall_o = !in_adv;

  // Convert in the chosen direction.
  always_comb begin
    if (op_e'(op_q) == OP_H2S) res_d = half_to_single(hb_q);
    else res_d = {16'd0, single_to_half(sb_q)};
  end

  // Hold control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_adv) in_vld_q <= valid_i;
      if (out_adv) out_vld_q <= in_vld_q;
    end
  end

  // Capture payloads.
  always_ff @(posedge clk_i) begin
    if (in_adv && valid_i) begin
      op_q <= op_i;
      sb_q <= single_bits_i;
      hb_q <= half_bits_i;
    end
    if (out_adv && in_vld_q) res_q <= res_d;
  end

  assign valid_o          = out_vld_q;
  assign converted_bits_o = res_q;

endmodule

>>> dv/tb_half_single_float_converter.sv
`timescale 1ns / 1ps

module tb_half_single_float_converter;
  import hsfc_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic        op_i = 1'b0;
  logic [31:0] single_bits_i = '0;
  logic [15:0] half_bits_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [31:0] converted_bits_o;

  logic [31:0] expected_conv_q[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_off_cycles = 0;

  half_single_float_converter dut (
    .clk_i, .rst_ni, .valid_i, .stall_o, .op_i, .single_bits_i, .half_bits_i,
    .valid_o, .stall_i, .converted_bits_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Predict binary32 to binary16 by truncation, flushing tiny values.
  function automatic logic [15:0] predict_half(input logic [31:0] x);
    int e;
    logic [15:0] sgn;
    logic [23:0] full;
    sgn = {x[31], 15'd0};
    e = int'(x[30:23]) - 112;
    full = {1'b1, x[22:0]};
    if (e <= 0) begin
      if (e < -10) return sgn;
      return sgn | 16'(full >> (14 - e));
    end
    if (x[30:23] == 8'hff) return (x[22:0] != 0) ? (sgn | 16'h7e00) : (sgn | 16'h7c00);
    if (e > 30) return sgn | 16'h7c00;
    return sgn | 16'(e << 10) | 16'(x[22:13]);
  endfunction

  // Predict binary16 to binary32, which is exact.
  function automatic logic [31:0] predict_single(input logic [15:0] h);
    int lz;
    logic [9:0] m;
    logic [31:0] sgn;
    sgn = {h[15], 31'd0};
    m = h[9:0];
    lz = 0;
    if (h[14:10] == 5'd0) begin
      if (m == 0) return sgn;
      while (!m[9]) begin
        m = m << 1;
        lz++;
      end
      m = m << 1;
      return sgn | (32'(112 - lz) << 23) | (32'(m) << 13);
    end
    if (h[14:10] == 5'h1f) return sgn | (32'hff << 23) | (32'(h[9:0]) << 13);
    return sgn | (32'(h[14:10] + 112) << 23) | (32'(h[9:0]) << 13);
  endfunction

  // Offer one transaction after a random gap and hold it until accepted.
  task automatic send_item(input op_e op, input logic [31:0] s, input logic [15:0] h);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    op_i <= op;
    single_bits_i <= s;
    half_bits_i <= h;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    expected_conv_q.push_back(op == OP_S2H ? {16'd0, predict_half(s)} : predict_single(h));
  endtask

  task automatic send_random(input int unsigned n);
    logic [31:0] s;
    for (int unsigned i = 0; i < n; i++) begin
      s = $urandom;
      // Bias exponents toward the interesting half range.
      if ($urandom_range(1)) s[30:23] = 8'($urandom_range(95, 145));
      send_item(op_e'($urandom_range(1)), s, 16'($urandom));
    end
  endtask

  // Drop valid and wait for every outstanding result.
  task automatic drain();
    valid_i <= 1'b0;
    while (expected_conv_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [31:0] singles[15] = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h3880_0000,
      32'h3300_0000, 32'h32ff_ffff, 32'h477f_e000, 32'h4780_0000, 32'hff80_0000,
      32'h7f80_0001, 32'hffc0_0000, 32'h3f80_0000, 32'h387f_ffff, 32'hffff_ffff, 32'hc7ff_ffff};
    logic [15:0] halves[10] = '{16'h0000, 16'h8000, 16'h0001, 16'h83ff, 16'h0200,
      16'h7c00, 16'hfc00, 16'h7dff, 16'hffff, 16'h3c00};
    foreach (singles[i]) send_item(OP_S2H, singles[i], 16'($urandom));
    foreach (halves[i]) send_item(OP_H2S, $urandom, halves[i]);
    drain();
  endtask

  task automatic test_idling();
    send_idle_pct = 37;
    recv_idle_pct = 66;
    send_random(500);
    send_idle_pct = 66;
    recv_idle_pct = 37;
    send_random(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(600);
    drain();
  endtask

  task automatic test_backpressure();
    hold_off_cycles = 40;
    send_random(60);
    drain();
  endtask

  // Drive the receiver stall, with an optional long hold-off.
  always @(posedge clk_i) begin
    if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      stall_i <= 1'b1;
    end else begin
      stall_i <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Check each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_conv_q.size() == 0) begin
        $error("converted_bits: unexpected result %h", converted_bits_o);
        fail_count++;
      end else if (converted_bits_o !== expected_conv_q[0]) begin
        $error("converted_bits: expected %h actual %h", expected_conv_q[0], converted_bits_o);
        fail_count++;
        void'(expected_conv_q.pop_front());
      end else begin
        void'(expected_conv_q.pop_front());
      end
    end
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[half_single_float_converter] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_idling();
    test_backpressure();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && expected_conv_q.size() == 0) begin
      $display("[half_single_float_converter] OK");
    end else begin
      $display("[half_single_float_converter] ERROR");
    end
    $finish;
  end

endmodule
